### rtl/core/matrix_keypad_scanner_code_lock_core_defines.svh
// Assertion helpers used by the keypad lock skid buffer
`ifndef MATRIX_KEYPAD_SCANNER_CODE_LOCK_CORE_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_CODE_LOCK_CORE_DEFINES_SVH

// Condition that must hold on every clock edge out of reset
`define MKSCL_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define MKSCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mkscl_pkg.sv
`default_nettype none
package mkscl_pkg;

	localparam int unsigned NUM_DIGITS = 4;

	typedef logic [3:0] key_t;
	typedef logic [1:0] cfg_idx_t;

	// code register indexes
	localparam cfg_idx_t CFG_DIGIT_FIRST  = 2'd0;
	localparam cfg_idx_t CFG_DIGIT_SECOND = 2'd1;
	localparam cfg_idx_t CFG_DIGIT_THIRD  = 2'd2;
	localparam cfg_idx_t CFG_DIGIT_FOURTH = 2'd3;

	localparam key_t CODE_RESET_FIRST  = 4'd6;
	localparam key_t CODE_RESET_SECOND = 4'd9;
	localparam key_t CODE_RESET_THIRD  = 4'd6;
	localparam key_t CODE_RESET_FOURTH = 4'd9;

	localparam key_t KEY_A    = 4'd10;
	localparam key_t KEY_B    = 4'd11;
	localparam key_t KEY_C    = 4'd12;
	localparam key_t KEY_D    = 4'd13;
	localparam key_t KEY_STAR = 4'd14;
	localparam key_t KEY_HASH = 4'd15;

	typedef struct packed {
		logic [3:0] column_drive;
		logic       key_valid;
		key_t       key_index;
		key_t       last_key;
		logic       code_done;
		logic       unlocked;
	} result_t;

	function automatic key_t key_lookup(input logic [1:0] row, input logic [1:0] col);
		key_t k;
		k = 4'd0;
		case ({row, col})
			4'b00_00: k = 4'd1;
			4'b00_01: k = 4'd2;
			4'b00_10: k = 4'd3;
			4'b00_11: k = KEY_A;
			4'b01_00: k = 4'd4;
			4'b01_01: k = 4'd5;
			4'b01_10: k = 4'd6;
			4'b01_11: k = KEY_B;
			4'b10_00: k = 4'd7;
			4'b10_01: k = 4'd8;
			4'b10_10: k = 4'd9;
			4'b10_11: k = KEY_C;
			4'b11_00: k = KEY_STAR;
			4'b11_01: k = 4'd0;
			4'b11_10: k = KEY_HASH;
			4'b11_11: k = KEY_D;
			default:  k = 4'd0;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

### rtl/core/matrix_keypad_scanner_code_lock_core.sv
// Keypad scanner with four-key code lock.
// Each result is registered in the output buffer as its tick is accepted.
// Throughput: one tick per cycle; a two-entry output buffer lets intake run
// while a result waits, stalling only when both entries are full.
// Reset (arst_n low, asynchronous): scan at column 0, no press held, lock
// closed, last key 0, code digits 6 9 6 9, output buffer empty.
`default_nettype none
module matrix_keypad_scanner_code_lock_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [3:0]           row_levels,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [3:0]                column_drive,
	output logic                      key_valid,
	output logic [3:0]                key_index,
	output logic [3:0]                last_key,
	output logic                      code_done,
	output logic                      unlocked,
	input  wire logic                 cfg_we,
	input  wire mkscl_pkg::cfg_idx_t  cfg_index,
	input  wire logic [3:0]           cfg_data
);
	import mkscl_pkg::*;

	key_t       code_q [NUM_DIGITS];
	logic [1:0] scan_col_q;
	logic       await_q;
	logic [1:0] held_row_q;
	key_t       last_key_q;
	logic [1:0] entry_cnt_q;
	logic       mismatch_q;
	logic       unlock_q;

	logic [1:0] scan_col_d;
	logic       await_d;
	logic [1:0] held_row_d;
	key_t       last_key_d;
	logic [1:0] entry_cnt_d;
	logic       mismatch_d;
	logic       unlock_d;
	logic       accept;
	logic       release_hit;
	logic [1:0] first_row;
	key_t       key;
	logic       done;
	result_t    res;
	result_t    res_out;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q[CFG_DIGIT_FIRST]  <= CODE_RESET_FIRST;
			code_q[CFG_DIGIT_SECOND] <= CODE_RESET_SECOND;
			code_q[CFG_DIGIT_THIRD]  <= CODE_RESET_THIRD;
			code_q[CFG_DIGIT_FOURTH] <= CODE_RESET_FOURTH;
		end else if (cfg_we) begin
			code_q[cfg_index] <= cfg_data;
		end
	end

	// lowest numbered high row wins
	always_comb begin
		if (row_levels[0]) begin
			first_row = 2'd0;
		end else if (row_levels[1]) begin
			first_row = 2'd1;
		end else if (row_levels[2]) begin
			first_row = 2'd2;
		end else begin
			first_row = 2'd3;
		end
	end

	assign release_hit = await_q && !row_levels[held_row_q];

	always_comb begin
		scan_col_d  = scan_col_q;
		await_d     = await_q;
		held_row_d  = held_row_q;
		last_key_d  = last_key_q;
		entry_cnt_d = entry_cnt_q;
		mismatch_d  = mismatch_q;
		unlock_d    = unlock_q;
		key         = 4'd0;
		done        = 1'b0;
		if (release_hit) begin
			key        = key_lookup(held_row_q, scan_col_q);
			last_key_d = key;
			if (entry_cnt_q == 2'd3) begin
				done        = 1'b1;
				unlock_d    = !(mismatch_q || (key != code_q[entry_cnt_q]));
				entry_cnt_d = 2'd0;
				mismatch_d  = 1'b0;
			end else begin
				entry_cnt_d = entry_cnt_q + 2'd1;
				mismatch_d  = mismatch_q || (key != code_q[entry_cnt_q]);
			end
			scan_col_d = 2'd0;
			await_d    = 1'b0;
		end else if (!await_q) begin
			if (row_levels == 4'd0) begin
				scan_col_d = scan_col_q + 2'd1;
			end else begin
				held_row_d = first_row;
				await_d    = 1'b1;
			end
		end
	end

	always_comb begin
		res.column_drive = 4'b0001 << scan_col_d;
		res.key_valid    = release_hit;
		res.key_index    = key;
		res.last_key     = last_key_d;
		res.code_done    = done;
		res.unlocked     = unlock_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_col_q  <= 2'd0;
			await_q     <= 1'b0;
			held_row_q  <= 2'd0;
			last_key_q  <= 4'd0;
			entry_cnt_q <= 2'd0;
			mismatch_q  <= 1'b0;
			unlock_q    <= 1'b0;
		end else if (accept) begin
			scan_col_q  <= scan_col_d;
			await_q     <= await_d;
			held_row_q  <= held_row_d;
			last_key_q  <= last_key_d;
			entry_cnt_q <= entry_cnt_d;
			mismatch_q  <= mismatch_d;
			unlock_q    <= unlock_d;
		end
	end

	mkscl_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.has_room  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (res_out)
	);

	assign column_drive = res_out.column_drive;
	assign key_valid    = res_out.key_valid;
	assign key_index    = res_out.key_index;
	assign last_key     = res_out.last_key;
	assign code_done    = res_out.code_done;
	assign unlocked     = res_out.unlocked;

endmodule
`default_nettype wire

### rtl/core/mkscl_skid.sv
`default_nettype none
`include "matrix_keypad_scanner_code_lock_core_defines.svh"
module mkscl_skid (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire mkscl_pkg::result_t push_data,
	output logic                   has_room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output mkscl_pkg::result_t     out_data
);
	import mkscl_pkg::*;

	result_t    head_q;
	result_t    tail_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign has_room  = (cnt_q != 2'd2);
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload slots, no reset
	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) head_q <= push_data;
				else tail_q <= push_data;
			end
			2'b01: begin
				head_q <= tail_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					head_q <= push_data;
				end else begin
					head_q <= tail_q;
					tail_q <= push_data;
				end
			end
			default: begin
				head_q <= head_q;
			end
		endcase
	end

	`MKSCL_ASSERT_ALWAYS(a_cnt_max, cnt_q <= 2'd2, "skid count overflow")
	`MKSCL_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 2'd1, "count not raised")
	`MKSCL_ASSERT_NEXT(a_cnt_dn, pop && !push, cnt_q == $past(cnt_q) - 2'd1, "count not lowered")
	`MKSCL_ASSERT_NEXT(a_tail_fwd, pop && !push && cnt_q == 2'd2,
		out_data == $past(tail_q), "queued request lost")

endmodule
`default_nettype wire
